// ===== rtl/assert_macros.svh =====
// assertion macros shared by the hasher rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SHA1_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sha1 assertion failed");

// condition that must never be true outside reset
`define SHA1_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sha1 forbidden condition seen");

`endif

// ===== rtl/sha1_pkg.sv =====
// types and constants of the sha-1 hasher
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

  // input operation codes
  localparam logic OpAbsorb = 1'b0;
  localparam logic OpFinish = 1'b1;

  // initial chaining values
  localparam logic [31:0] InitH0 = 32'h67452301;
  localparam logic [31:0] InitH1 = 32'hEFCDAB89;
  localparam logic [31:0] InitH2 = 32'h98BADCFE;
  localparam logic [31:0] InitH3 = 32'h10325476;
  localparam logic [31:0] InitH4 = 32'hC3D2E1F0;

  // round constants
  localparam logic [31:0] RoundK0 = 32'h5A827999;
  localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

  // first padding byte
  localparam logic [7:0] PadByte = 8'h80;

  localparam int unsigned Rounds      = 80;
  localparam int unsigned BlockWords  = 16;
  localparam int unsigned DigestWords = 5;

  // one 32-bit message word on its way from the front to the core
  typedef struct packed {
    logic        last;  // final length word of a message
    logic [31:0] word;
  } word_entry_t;

endpackage

`default_nettype wire

// ===== rtl/sha1_fifo.sv =====
// word queue between the byte front end and the compression core
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sha1_fifo #(
  parameter int unsigned Depth = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  wire sha1_pkg::word_entry_t wdata_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output logic                  empty_o,
  output sha1_pkg::word_entry_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sha1_pkg::word_entry_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // occupancy never runs past the depth
  `SHA1_ASSERT(a_fifo_count_bound, count_q <= CntW'(Depth))
  // a lone push grows the queue by exactly one entry
  `SHA1_ASSERT(a_fifo_push_grows, (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))

endmodule

`default_nettype wire

// ===== rtl/sha1_front.sv =====
// byte front end: packs message bytes into words and generates padding
`timescale 1ns / 1ps
`default_nettype none

module sha1_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  output logic                  full_o,
  input  wire                   op_i,
  input  wire  [7:0]            data_byte_i,
  output logic                  wpush_o,
  output sha1_pkg::word_entry_t wdata_o,
  input  wire                   wfull_i
);

  typedef enum logic [1:0] {
    StIdle,
    StPadZero,
    StLenHi,
    StLenLo
  } front_state_e;

  front_state_e state_q, state_d;
  logic [23:0]  acc_q, acc_d;
  logic [1:0]   bcnt_q, bcnt_d;
  logic [3:0]   wcnt_q, wcnt_d;
  logic [63:0]  bits_q, bits_d;
  logic         accept;
  logic [31:0]  pad_word;

  assign full_o = (state_q != StIdle) || wfull_i;
  assign accept = push_i && !full_o;

  // last partial word with the padding byte placed after the held bytes
  always_comb begin
    case (bcnt_q)
      2'd0:    pad_word = {sha1_pkg::PadByte, 24'h0};
      2'd1:    pad_word = {acc_q[7:0], sha1_pkg::PadByte, 16'h0};
      2'd2:    pad_word = {acc_q[15:0], sha1_pkg::PadByte, 8'h0};
      default: pad_word = {acc_q[23:0], sha1_pkg::PadByte};
    endcase
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    bcnt_d  = bcnt_q;
    wcnt_d  = wcnt_q;
    bits_d  = bits_q;
    wpush_o = 1'b0;
    wdata_o = '{last: 1'b0, word: '0};
    unique case (state_q)
      StIdle: begin
        if (accept && (op_i == sha1_pkg::OpAbsorb)) begin
          acc_d  = {acc_q[15:0], data_byte_i};
          bcnt_d = bcnt_q + 1'b1;
          bits_d = bits_q + 64'd8;
          if (bcnt_q == 2'd3) begin
            wpush_o = 1'b1;
            wdata_o = '{last: 1'b0, word: {acc_q, data_byte_i}};
            wcnt_d  = wcnt_q + 1'b1;
          end
        end else if (accept) begin
          wpush_o = 1'b1;
          wdata_o = '{last: 1'b0, word: pad_word};
          wcnt_d  = wcnt_q + 1'b1;
          bcnt_d  = '0;
          state_d = StPadZero;
        end
      end
      StPadZero: begin
        if (wcnt_q == 4'd14) begin
          state_d = StLenHi;
        end else if (!wfull_i) begin
          wpush_o = 1'b1;
          wcnt_d  = wcnt_q + 1'b1;
        end
      end
      StLenHi: begin
        if (!wfull_i) begin
          wpush_o = 1'b1;
          wdata_o = '{last: 1'b0, word: bits_q[63:32]};
          wcnt_d  = wcnt_q + 1'b1;
          state_d = StLenLo;
        end
      end
      StLenLo: begin
        if (!wfull_i) begin
          wpush_o = 1'b1;
          wdata_o = '{last: 1'b1, word: bits_q[31:0]};
          wcnt_d  = '0;
          bits_d  = '0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bcnt_q  <= '0;
      wcnt_q  <= '0;
      bits_q  <= '0;
    end else begin
      state_q <= state_d;
      bcnt_q  <= bcnt_d;
      wcnt_q  <= wcnt_d;
      bits_q  <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

`default_nettype wire

// ===== rtl/sha1_core.sv =====
// compression core: schedule, 80 rounds, chaining update and digest beats
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sha1_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   wempty_i,
  input  wire sha1_pkg::word_entry_t wdata_i,
  output logic                  wpop_o,
  output logic                  empty_o,
  input  wire                   pop_i,
  output logic [31:0]           digest_word_o,
  output logic [2:0]            word_index_o,
  output logic                  is_last_o
);

  typedef enum logic [1:0] {
    StLoad,
    StRound,
    StAdd,
    StOut
  } core_state_e;

  core_state_e state_q;
  logic [31:0] sched_q [sha1_pkg::BlockWords];
  logic [31:0] h_q [sha1_pkg::DigestWords];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [3:0]  lcnt_q;
  logic [6:0]  rnd_q;
  logic [2:0]  idx_q;
  logic        last_q;
  logic [31:0] f_val, k_val, sched_new, tmp_val, sched_x;
  logic        shift_en;

  assign wpop_o        = (state_q == StLoad) && !wempty_i;
  assign empty_o       = (state_q != StOut);
  assign digest_word_o = h_q[idx_q];
  assign word_index_o  = idx_q;
  assign is_last_o     = (idx_q == 3'(sha1_pkg::DigestWords - 1));

  // round function and constant by quarter
  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = sha1_pkg::RoundK0;
    end else if (rnd_q < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = sha1_pkg::RoundK1;
    end else if (rnd_q < 7'd60) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = sha1_pkg::RoundK2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = sha1_pkg::RoundK3;
    end
  end

  assign sched_x   = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
  assign sched_new = (state_q == StLoad) ? wdata_i.word : {sched_x[30:0], sched_x[31]};
  assign tmp_val   = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + sched_q[0];
  assign shift_en  = wpop_o || (state_q == StRound);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      lcnt_q  <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
      h_q[0]  <= sha1_pkg::InitH0;
      h_q[1]  <= sha1_pkg::InitH1;
      h_q[2]  <= sha1_pkg::InitH2;
      h_q[3]  <= sha1_pkg::InitH3;
      h_q[4]  <= sha1_pkg::InitH4;
    end else begin
      unique case (state_q)
        StLoad: begin
          if (wpop_o) begin
            lcnt_q <= lcnt_q + 1'b1;
            if (lcnt_q == 4'(sha1_pkg::BlockWords - 1)) begin
              last_q  <= wdata_i.last;
              rnd_q   <= '0;
              state_q <= StRound;
            end
          end
        end
        StRound: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == 7'(sha1_pkg::Rounds - 1)) begin
            state_q <= StAdd;
          end
        end
        StAdd: begin
          h_q[0] <= h_q[0] + a_q;
          h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q;
          h_q[4] <= h_q[4] + e_q;
          idx_q  <= '0;
          state_q <= last_q ? StOut : StLoad;
        end
        StOut: begin
          if (pop_i) begin
            if (is_last_o) begin
              // digest delivered, start over for the next message
              h_q[0]  <= sha1_pkg::InitH0;
              h_q[1]  <= sha1_pkg::InitH1;
              h_q[2]  <= sha1_pkg::InitH2;
              h_q[3]  <= sha1_pkg::InitH3;
              h_q[4]  <= sha1_pkg::InitH4;
              state_q <= StLoad;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  // working variables and the 16-word schedule window
  always_ff @(posedge clk_i) begin
    if (wpop_o && (lcnt_q == 4'(sha1_pkg::BlockWords - 1))) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (state_q == StRound) begin
      a_q <= tmp_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
    if (shift_en) begin
      for (int i = 0; i < sha1_pkg::BlockWords - 1; i++) begin
        sched_q[i] <= sched_q[i+1];
      end
      sched_q[sha1_pkg::BlockWords-1] <= sched_new;
    end
  end

  // a digest beat never carries an index past the last word
  `SHA1_ASSERT(a_core_index_bound, !empty_o |-> (idx_q <= 3'(sha1_pkg::DigestWords - 1)))
  // no word is taken from the queue while rounds are running
  `SHA1_NEVER(a_core_pop_in_round, wpop_o && (state_q != StLoad))

endmodule

`default_nettype wire

// ===== rtl/sha1_message_hasher.sv =====
// top level of the byte-stream sha-1 hasher
//
//   channel   direction  handshake          beat payload
//   input     in         push_i / full_o    op_i, data_byte_i
//   digest    out        pop_i / empty_o    digest_word_o, word_index_o, is_last_o
//
// an absorb beat is taken whenever the word queue has room;
// every fourth byte becomes one queue word.
// the core loads a block word by word from the queue, runs the rounds (one round
// per cycle in a single shared round unit) and then does the chaining add,
// so the core round loop sets the sustained byte rate.
// a finish beat holds off the input while padding and the bit count are queued;
// the five digest beats then wait in the chaining registers.
// reset loads the initial hash values and empties the queue; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_hasher #(
  parameter int unsigned FifoDepth = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input beats
  input  wire         push_i,
  output logic        full_o,
  input  wire         op_i,
  input  wire  [7:0]  data_byte_i,
  // digest beats
  output logic        empty_o,
  input  wire         pop_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        is_last_o
);

  // word traffic between front end, queue and core
  logic                  f_push, f_full;
  sha1_pkg::word_entry_t f_data;
  logic                  c_pop, c_empty;
  sha1_pkg::word_entry_t c_data;

  // front end: byte packing, bit count and padding sequencer
  sha1_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .wpush_o     (f_push),
    .wdata_o     (f_data),
    .wfull_i     (f_full)
  );

  // decoupling queue, lets the next block arrive during the rounds
  sha1_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_data),
    .full_o  (f_full),
    .pop_i   (c_pop),
    .empty_o (c_empty),
    .rdata_o (c_data)
  );

  // back end: compression and digest delivery
  sha1_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wempty_i      (c_empty),
    .wdata_i       (c_data),
    .wpop_o        (c_pop),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .is_last_o     (is_last_o)
  );

endmodule

`default_nettype wire
